[sv/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg - shared types and constants of the sequence tracker
// Request codes, field widths, register indexes, controller state and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int SEQ_W     = 12;
	localparam int CNT_OUT_W = 16;
	localparam int LOST_W    = 13;
	localparam int TOTAL_W   = 13;
	localparam int REQ_W     = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [REQ_W-1:0] REQ_OBSERVE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FINALIZE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_KNOWN    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TOTAL = 1'd1;

	localparam logic [LOST_W-1:0] LOST_MAX = 13'h1FFF;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_OBS_RD,
		ST_OBS_UPD,
		ST_FIN,
		ST_FIN_END,
		ST_CLR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;    // capture request payload, restart sweep index
		logic obs_upd;   // resolve observe with map read data
		logic fin_step;  // read one map entry of the finalize walk
		logic clr_step;  // zero one map entry
		logic clr_regs;  // zero counters and highest-seen state
		logic res_load;  // load result register
	} cmd_t;

	typedef struct packed {
		logic fin_skip;  // finalize has no bound
		logic fin_last;  // sweep index sits on the finalize bound
		logic clr_last;  // sweep index sits on the last map entry
	} sts_t;

endpackage

[sv/slt_ram.sv]
// ----------------------------------------------------------------------------
// slt_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module slt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/slt_ctrl.sv]
// ----------------------------------------------------------------------------
// slt_ctrl - request sequencer of the sequence tracker
// Accepts requests, steps observe, finalize walk and clear sweep, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module slt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [slt_pkg::REQ_W-1:0]   req_type,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  slt_pkg::sts_t               sts,
	output slt_pkg::cmd_t               cmd
);

	slt_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slt_pkg::ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_free = !out_valid_q || out_ready;
		case (state_q)
			slt_pkg::ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.clr_regs = 1'b1;
					state_d      = slt_pkg::ST_IDLE;
				end
			end
			slt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			slt_pkg::ST_OBS_RD: begin
				state_d = slt_pkg::ST_OBS_UPD;
			end
			slt_pkg::ST_OBS_UPD: begin
				// next request may enter while this one resolves
				if (out_free) begin
					cmd.obs_upd  = 1'b1;
					cmd.res_load = 1'b1;
					in_ready     = 1'b1;
					state_d      = slt_pkg::ST_IDLE;
				end
			end
			slt_pkg::ST_FIN: begin
				if (sts.fin_skip) begin
					state_d = slt_pkg::ST_DONE;
				end else begin
					cmd.fin_step = 1'b1;
					if (sts.fin_last) begin
						state_d = slt_pkg::ST_FIN_END;
					end
				end
			end
			slt_pkg::ST_FIN_END: begin
				// last read entry is counted here
				state_d = slt_pkg::ST_DONE;
			end
			slt_pkg::ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.clr_regs = 1'b1;
					state_d      = slt_pkg::ST_DONE;
				end
			end
			slt_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = slt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slt_pkg::ST_IDLE;
			end
		endcase

		cmd.accept = in_ready && in_valid;
		if (cmd.accept) begin
			case (req_type)
				slt_pkg::REQ_OBSERVE:  state_d = slt_pkg::ST_OBS_RD;
				slt_pkg::REQ_FINALIZE: state_d = slt_pkg::ST_FIN;
				slt_pkg::REQ_CLEAR:    state_d = slt_pkg::ST_CLR;
				default:               state_d = slt_pkg::ST_DONE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/slt_dpath.sv]
// ----------------------------------------------------------------------------
// slt_dpath - seen map, counters and result register
// Holds the seen map RAM, the map index reduction, counters, highest-seen
// state, configuration registers and the result register.
// ----------------------------------------------------------------------------
module slt_dpath #(
	parameter int SEQ_SPACE  = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  slt_pkg::cmd_t                    cmd,
	output slt_pkg::sts_t                    sts,
	input  logic [slt_pkg::SEQ_W-1:0]        seq,
	input  logic                             cfg_wen,
	input  logic [slt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slt_pkg::TOTAL_W-1:0]      cfg_wdata,
	output logic                             was_duplicate,
	output logic                             was_out_of_order,
	output logic [slt_pkg::CNT_OUT_W-1:0]    duplicate_count,
	output logic [slt_pkg::CNT_OUT_W-1:0]    out_of_order_count,
	output logic [slt_pkg::LOST_W-1:0]       lost_count,
	output logic [slt_pkg::SEQ_W-1:0]        highest_seen,
	output logic                             any_seen
);

	localparam int AW     = $clog2(SEQ_SPACE);
	localparam int EW     = (AW > slt_pkg::TOTAL_W) ? AW : slt_pkg::TOTAL_W;
	localparam int PW     = slt_pkg::SEQ_W + AW + 1;
	localparam int RSH    = 24;
	localparam int MW     = slt_pkg::SEQ_W + RSH;
	localparam int RECIP  = (1 << RSH) / SEQ_SPACE;
	localparam int CXW    = (COUNT_BITS > slt_pkg::CNT_OUT_W) ? COUNT_BITS
	                                                          : slt_pkg::CNT_OUT_W;

	// configuration
	logic                          total_known_q;
	logic [slt_pkg::TOTAL_W-1:0]   expected_total_q;

	// session state
	logic [COUNT_BITS-1:0]         dup_q, dup_n;
	logic [COUNT_BITS-1:0]         ooo_q, ooo_n;
	logic [slt_pkg::LOST_W-1:0]    lost_q, lost_n;
	logic [slt_pkg::SEQ_W-1:0]     high_q, high_n;
	logic                          any_q, any_n;
	logic                          dup_flag, ooo_flag;

	// request capture and index reduction
	logic [slt_pkg::SEQ_W-1:0]     seq_q;
	logic [slt_pkg::SEQ_W-1:0]     quot_q;
	logic [MW-1:0]                 quot_prod;
	logic [PW-1:0]                 qd, rem_raw, rem_fix;
	logic [AW-1:0]                 idx;

	// sweep
	logic [AW-1:0]                 sweep_q;
	logic                          pend_s1;
	logic [slt_pkg::TOTAL_W-1:0]   exp_m1;
	logic [EW-1:0]                 bound_raw;
	logic [AW-1:0]                 bound;

	// map
	logic                          map_wen;
	logic [AW-1:0]                 map_waddr;
	logic                          map_wdata;
	logic [AW-1:0]                 map_raddr;
	logic                          map_rdata;

	logic [CXW-1:0]                dup_ext, ooo_ext;

	// seq / SEQ_SPACE by reciprocal: the estimate is exact or one low
	assign quot_prod = MW'(seq) * MW'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seq_q  <= seq;
			quot_q <= quot_prod[MW-1:RSH];
		end
	end

	assign qd      = PW'(quot_q) * PW'(SEQ_SPACE);
	assign rem_raw = PW'(seq_q) - qd;
	assign rem_fix = (rem_raw >= PW'(SEQ_SPACE)) ? rem_raw - PW'(SEQ_SPACE) : rem_raw;
	assign idx     = rem_fix[AW-1:0];

	// finalize bound
	assign exp_m1    = expected_total_q - slt_pkg::TOTAL_W'(1);
	assign bound_raw = total_known_q ? EW'(exp_m1) : EW'(high_q);
	assign bound     = (bound_raw > EW'(SEQ_SPACE - 1)) ? AW'(SEQ_SPACE - 1)
	                                                    : bound_raw[AW-1:0];

	assign sts.fin_skip = total_known_q ? (expected_total_q == '0) : !any_q;
	assign sts.fin_last = (sweep_q == bound);
	assign sts.clr_last = (sweep_q == AW'(SEQ_SPACE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.fin_step;
			if (cmd.accept) begin
				sweep_q <= '0;
			end else if (cmd.fin_step || cmd.clr_step) begin
				sweep_q <= AW'(sweep_q + AW'(1));
			end
		end
	end

	assign map_raddr = cmd.fin_step ? sweep_q : idx;
	assign map_wen   = cmd.clr_step || (cmd.obs_upd && !map_rdata);
	assign map_waddr = cmd.clr_step ? sweep_q : idx;
	assign map_wdata = !cmd.clr_step;

	slt_ram #(
		.WIDTH (1),
		.DEPTH (SEQ_SPACE)
	) u_map (
		.clk   (clk),
		.wen   (map_wen),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// next session state
	always_comb begin
		dup_n    = dup_q;
		ooo_n    = ooo_q;
		lost_n   = lost_q;
		high_n   = high_q;
		any_n    = any_q;
		dup_flag = 1'b0;
		ooo_flag = 1'b0;
		if (cmd.obs_upd) begin
			if (map_rdata) begin
				dup_flag = 1'b1;
				if (!(&dup_q)) begin
					dup_n = dup_q + COUNT_BITS'(1);
				end
			end else begin
				if (any_q && (seq_q < high_q)) begin
					ooo_flag = 1'b1;
					if (!(&ooo_q)) begin
						ooo_n = ooo_q + COUNT_BITS'(1);
					end
				end
				if (!any_q || (seq_q > high_q)) begin
					high_n = seq_q;
				end
				any_n = 1'b1;
			end
		end
		if (pend_s1 && !map_rdata && (lost_q != slt_pkg::LOST_MAX)) begin
			lost_n = lost_q + slt_pkg::LOST_W'(1);
		end
		if (cmd.clr_regs) begin
			dup_n  = '0;
			ooo_n  = '0;
			lost_n = '0;
			high_n = '0;
			any_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q            <= '0;
			ooo_q            <= '0;
			lost_q           <= '0;
			high_q           <= '0;
			any_q            <= 1'b0;
			total_known_q    <= 1'b0;
			expected_total_q <= '0;
		end else begin
			dup_q  <= dup_n;
			ooo_q  <= ooo_n;
			lost_q <= lost_n;
			high_q <= high_n;
			any_q  <= any_n;
			if (cfg_wen) begin
				case (cfg_index)
					slt_pkg::CFG_TOTAL_KNOWN:    total_known_q    <= cfg_wdata[0];
					slt_pkg::CFG_EXPECTED_TOTAL: expected_total_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	assign dup_ext = CXW'(dup_n);
	assign ooo_ext = CXW'(ooo_n);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			was_duplicate      <= dup_flag;
			was_out_of_order   <= ooo_flag;
			duplicate_count    <= dup_ext[slt_pkg::CNT_OUT_W-1:0];
			out_of_order_count <= ooo_ext[slt_pkg::CNT_OUT_W-1:0];
			lost_count         <= lost_n;
			highest_seen       <= high_n;
			any_seen           <= any_n;
		end
	end

endmodule

[sv/sequence_loss_duplicate_tracker_unit.sv]
// ----------------------------------------------------------------------------
// sequence_loss_duplicate_tracker_unit - batch sequence loss/duplicate tracker
// Seen map with duplicate, out-of-order and lost counters.
// ----------------------------------------------------------------------------
// An observe request reads the one-bit seen map RAM, then resolves the result
// and writes the map back; with the output free, a new request may be accepted
// while the observe resolves. Finalize walks the map one entry per cycle
// through the RAM read port; clear zeroes the map one entry per cycle; an
// unused request code returns a result with the session state unchanged.
// After reset a clearing pass over the whole map runs with in_ready low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module sequence_loss_duplicate_tracker_unit #(
	parameter int SEQ_SPACE  = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [slt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slt_pkg::TOTAL_W-1:0]      cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [slt_pkg::REQ_W-1:0]        req_type,
	input  logic [slt_pkg::SEQ_W-1:0]        seq,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             was_duplicate,
	output logic                             was_out_of_order,
	output logic [slt_pkg::CNT_OUT_W-1:0]    duplicate_count,
	output logic [slt_pkg::CNT_OUT_W-1:0]    out_of_order_count,
	output logic [slt_pkg::LOST_W-1:0]       lost_count,
	output logic [slt_pkg::SEQ_W-1:0]        highest_seen,
	output logic                             any_seen
);

	slt_pkg::cmd_t cmd;
	slt_pkg::sts_t sts;

	slt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	slt_dpath #(
		.SEQ_SPACE  (SEQ_SPACE),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.seq                (seq),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.was_duplicate      (was_duplicate),
		.was_out_of_order   (was_out_of_order),
		.duplicate_count    (duplicate_count),
		.out_of_order_count (out_of_order_count),
		.lost_count         (lost_count),
		.highest_seen       (highest_seen),
		.any_seen           (any_seen)
	);

`ifndef NO_ASSERTIONS
	// a pending result is never overwritten
	a_res_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid || out_ready))
		else $error("result loaded over a pending transfer");

	// observe needs its map read cycle before anything else enters
	a_obs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (req_type == slt_pkg::REQ_OBSERVE)) |=> !in_ready)
		else $error("request accepted during observe map read");

	// no request enters while a map sweep runs
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!cmd.fin_step && !cmd.clr_step))
		else $error("request accepted during map sweep");

	// with nothing seen there is no highest and no out-of-order arrival
	a_empty_session: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !any_seen) |-> ((highest_seen == '0) && (out_of_order_count == '0)))
		else $error("empty session reports sequence state");
`endif

endmodule

[tb/tb_sequence_loss_duplicate_tracker_unit.sv]
// ----------------------------------------------------------------------------
// tb_sequence_loss_duplicate_tracker_unit - sequence tracker testbench
// Drives observe, finalize, clear and unused requests through the input
// channel under several bound settings. A scoreboard keeps its own seen map,
// counters and registers, and compares every result field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sequence_loss_duplicate_tracker_unit;

	localparam logic [slt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int MAP_DEPTH   = 4096;
	localparam int STALL_LIMIT = 20000;
	localparam int DUP_BURST   = 16;
	localparam int RAND_PHASES = 11;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic                          dup;
		logic                          ooo;
		logic [slt_pkg::CNT_OUT_W-1:0] dup_cnt;
		logic [slt_pkg::CNT_OUT_W-1:0] ooo_cnt;
		logic [slt_pkg::LOST_W-1:0]    lost_cnt;
		logic [slt_pkg::SEQ_W-1:0]     highest;
		logic                          any;
	} tracker_result_t;

	class tracker_scoreboard;
		bit                            seen_map_q[MAP_DEPTH];
		logic [slt_pkg::CNT_OUT_W-1:0] dup_cnt;
		logic [slt_pkg::CNT_OUT_W-1:0] ooo_cnt;
		logic [slt_pkg::LOST_W-1:0]    lost_cnt;
		logic [slt_pkg::SEQ_W-1:0]     highest;
		logic                          any;
		logic                          total_known;
		logic [slt_pkg::TOTAL_W-1:0]   expected_total;
		tracker_result_t               expected_q[$];
		int                            errors;
		int                            shown;

		function new();
			clear_session();
			total_known    = 1'b0;
			expected_total = '0;
			errors         = 0;
			shown          = 0;
		endfunction

		function void clear_session();
			foreach (seen_map_q[i])
				seen_map_q[i] = 1'b0;
			dup_cnt  = '0;
			ooo_cnt  = '0;
			lost_cnt = '0;
			highest  = '0;
			any      = 1'b0;
		endfunction

		function void set_reg(logic [slt_pkg::CFG_IDX_W-1:0] idx,
			logic [slt_pkg::TOTAL_W-1:0] val);
			if (idx == slt_pkg::CFG_TOTAL_KNOWN)
				total_known = val[0];
			else
				expected_total = val;
		endfunction

		function void count_lost();
			int bound;
			if (total_known) begin
				if (expected_total == '0)
					return;
				bound = int'(expected_total) - 1;
			end else begin
				if (!any)
					return;
				bound = int'(highest);
			end
			if (bound > MAP_DEPTH - 1)
				bound = MAP_DEPTH - 1;
			for (int i = 0; i <= bound; i++)
				if (!seen_map_q[i] && lost_cnt != slt_pkg::LOST_MAX)
					lost_cnt++;
		endfunction

		// predict the result of one accepted request
		function void note_input(logic [slt_pkg::REQ_W-1:0] rtype,
			logic [slt_pkg::SEQ_W-1:0] s);
			tracker_result_t r;
			r = '0;
			case (rtype)
				slt_pkg::REQ_OBSERVE: begin
					if (seen_map_q[s]) begin
						r.dup = 1'b1;
						if (dup_cnt != '1)
							dup_cnt++;
					end else begin
						if (any && s < highest) begin
							r.ooo = 1'b1;
							if (ooo_cnt != '1)
								ooo_cnt++;
						end
						seen_map_q[s] = 1'b1;
						if (!any || s > highest)
							highest = s;
						any = 1'b1;
					end
				end
				slt_pkg::REQ_FINALIZE: count_lost();
				slt_pkg::REQ_CLEAR:    clear_session();
				default: ;
			endcase
			r.dup_cnt  = dup_cnt;
			r.ooo_cnt  = ooo_cnt;
			r.lost_cnt = lost_cnt;
			r.highest  = highest;
			r.any      = any;
			expected_q = {expected_q, r};
		endfunction

		function void compare(string field, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				if (shown < 40) begin
					shown++;
					$display("%0t: %s mismatch, expected %0d, actual %0d",
						$time, field, exp_v, act_v);
				end
			end
		endfunction

		function void check_result(tracker_result_t got);
			tracker_result_t exp_r;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no request waiting, expected none, actual %h",
					$time, got);
				return;
			end
			exp_r = expected_q.pop_front();
			compare("was_duplicate",      exp_r.dup,      got.dup);
			compare("was_out_of_order",   exp_r.ooo,      got.ooo);
			compare("duplicate_count",    exp_r.dup_cnt,  got.dup_cnt);
			compare("out_of_order_count", exp_r.ooo_cnt,  got.ooo_cnt);
			compare("lost_count",         exp_r.lost_cnt, got.lost_cnt);
			compare("highest_seen",       exp_r.highest,  got.highest);
			compare("any_seen",           exp_r.any,      got.any);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wen;
	logic [slt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [slt_pkg::TOTAL_W-1:0]   cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic [slt_pkg::REQ_W-1:0]     req_type;
	logic [slt_pkg::SEQ_W-1:0]     seq;
	logic                          out_valid;
	logic                          out_ready;
	logic                          was_duplicate;
	logic                          was_out_of_order;
	logic [slt_pkg::CNT_OUT_W-1:0] duplicate_count;
	logic [slt_pkg::CNT_OUT_W-1:0] out_of_order_count;
	logic [slt_pkg::LOST_W-1:0]    lost_count;
	logic [slt_pkg::SEQ_W-1:0]     highest_seen;
	logic                          any_seen;

	tracker_scoreboard tracker;
	bit                no_idle;
	int                stall_cycles = 0;

	sequence_loss_duplicate_tracker_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.req_type           (req_type),
		.seq                (seq),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.was_duplicate      (was_duplicate),
		.was_out_of_order   (was_out_of_order),
		.duplicate_count    (duplicate_count),
		.out_of_order_count (out_of_order_count),
		.lost_count         (lost_count),
		.highest_seen       (highest_seen),
		.any_seen           (any_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// valid stays high after a transfer; the caller either sends the next
	// request in the same step or lowers valid in that step
	task automatic send_req(input logic [slt_pkg::REQ_W-1:0] rtype,
		input logic [slt_pkg::SEQ_W-1:0] s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rtype;
		seq      <= s;
		do @(posedge clk); while (!in_ready);
		tracker.note_input(rtype, s);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [slt_pkg::CFG_IDX_W-1:0] idx,
		input logic [slt_pkg::TOTAL_W-1:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		tracker.set_reg(idx, val);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_bounds(input logic tk, input logic [slt_pkg::TOTAL_W-1:0] total);
		logic [slt_pkg::TOTAL_W-1:0] tk_word;
		wait_drained();
		// upper bits of the flag word are don't-care
		tk_word = {slt_pkg::TOTAL_W{1'b0}};
		tk_word[slt_pkg::TOTAL_W-1:1] = (slt_pkg::TOTAL_W-1)'($urandom_range(0, 4095));
		tk_word[0] = tk;
		write_reg(slt_pkg::CFG_TOTAL_KNOWN, tk_word);
		write_reg(slt_pkg::CFG_EXPECTED_TOTAL, total);
	endtask

	// result sink with random back-pressure per transfer
	initial begin : sink
		int n;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin : monitor
		tracker_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.dup      = was_duplicate;
			got.ooo      = was_out_of_order;
			got.dup_cnt  = duplicate_count;
			got.ooo_cnt  = out_of_order_count;
			got.lost_cnt = lost_count;
			got.highest  = highest_seen;
			got.any      = any_seen;
			tracker.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		logic [slt_pkg::SEQ_W-1:0] next_seq;
		logic [slt_pkg::SEQ_W-1:0] s;
		int                        r;
		tracker   = new();
		no_idle   = 1'b0;
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		req_type  <= slt_pkg::REQ_OBSERVE;
		seq       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bound from highest seen
		set_bounds(1'b0, '0);
		send_req(slt_pkg::REQ_FINALIZE, 12'h000);  // nothing seen yet
		send_req(slt_pkg::REQ_OBSERVE, 12'h000);
		send_req(slt_pkg::REQ_OBSERVE, 12'hFFF);
		send_req(slt_pkg::REQ_OBSERVE, 12'h000);   // duplicate
		send_req(slt_pkg::REQ_OBSERVE, 12'h064);   // below highest
		send_req(slt_pkg::REQ_OBSERVE, 12'hFFF);
		send_req(REQ_UNUSED, 12'hFFF);
		send_req(slt_pkg::REQ_FINALIZE, 12'h000);
		send_req(slt_pkg::REQ_FINALIZE, 12'hA5A);  // adds again
		send_req(slt_pkg::REQ_FINALIZE, 12'h5A5);  // lost counter saturates
		send_req(slt_pkg::REQ_CLEAR, 12'h000);
		send_req(slt_pkg::REQ_OBSERVE, 12'h005);
		send_req(slt_pkg::REQ_OBSERVE, 12'h003);
		send_req(slt_pkg::REQ_OBSERVE, 12'h004);
		send_req(slt_pkg::REQ_FINALIZE, 12'h000);

		// directed: bound from expected total
		set_bounds(1'b1, '0);
		send_req(slt_pkg::REQ_FINALIZE, 12'h000);  // zero total, no counting
		set_bounds(1'b1, 13'd1);
		send_req(slt_pkg::REQ_FINALIZE, 12'h000);
		set_bounds(1'b1, 13'h1FFF);                // bound beyond the map
		send_req(slt_pkg::REQ_FINALIZE, 12'h000);
		set_bounds(1'b1, 13'd4096);
		send_req(slt_pkg::REQ_FINALIZE, 12'h000);
		send_req(slt_pkg::REQ_CLEAR, 12'h000);

		// duplicate run, back to back
		wait_drained();
		no_idle = 1'b1;
		send_req(slt_pkg::REQ_OBSERVE, 12'h04D);
		repeat (DUP_BURST)
			send_req(slt_pkg::REQ_OBSERVE, 12'h04D);
		send_req(slt_pkg::REQ_CLEAR, 12'h000);
		wait_drained();
		no_idle = 1'b0;

		// random sessions
		for (int p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0, 1: set_bounds(1'b0, 13'($urandom_range(0, 8191)));
				2:    set_bounds(1'b1, 13'($urandom_range(0, 64)));
				3:    set_bounds(1'b1, 13'($urandom_range(0, 4096)));
				4:    set_bounds(1'b1, 13'd4096);
				default: set_bounds(1'b1, 13'($urandom_range(0, 8191)));
			endcase
			no_idle  = ($urandom_range(0, 3) == 0);
			next_seq = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
				12'($urandom_range(0, 64));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 86) begin
					r = $urandom_range(0, 99);
					if (r < 60) begin
						s = next_seq;
						next_seq++;
					end else if (r < 75) begin
						s = next_seq - 12'($urandom_range(1, 8));
					end else if (r < 85) begin
						next_seq += 12'($urandom_range(1, 5));
						s = next_seq;
					end else begin
						s = 12'($urandom);
					end
					send_req(slt_pkg::REQ_OBSERVE, s);
				end else if (r < 92) begin
					send_req(slt_pkg::REQ_FINALIZE, 12'($urandom));
				end else if (r < 94) begin
					send_req(slt_pkg::REQ_CLEAR, 12'($urandom));
					next_seq = 12'($urandom_range(0, 64));
				end else begin
					send_req(REQ_UNUSED, 12'($urandom));
				end
				// occasionally hold off until everything is back
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (tracker.pending() != 0) begin
			tracker.errors++;
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, tracker.pending());
		end
		if (tracker.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
sv/slt_pkg.sv
sv/slt_ram.sv
sv/slt_ctrl.sv
sv/slt_dpath.sv
sv/sequence_loss_duplicate_tracker_unit.sv
tb/tb_sequence_loss_duplicate_tracker_unit.sv
